// ===== design/stb_pkg.sv =====
// Shared types, codes and constants of the software timer bank.
package stb_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int TICK_WIDTH_DEF = 32;
	localparam int MAX_RESULTS    = 16;

	localparam int FUNC_W   = 3;
	localparam int ID_W     = 4;
	localparam int PERIOD_W = 32;
	localparam int LEFT_W   = 32;
	localparam int COUNT_W  = 5;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_INVAL = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FN_CONFIG  = 3'd0,
		FN_START   = 3'd1,
		FN_STOP    = 3'd2,
		FN_RESTART = 3'd3,
		FN_TICK    = 3'd4,
		FN_QUERY   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                status;
		logic                expired;
		logic [ID_W-1:0]     result_timer;
		logic                is_active;
		logic [LEFT_W-1:0]   ticks_left;
		logic [COUNT_W-1:0]  armed_count;
		logic                last;
	} res_t;

endpackage

// ===== design/stb_ifs.sv =====
// Valid/ready channel interfaces for command beats and result beats.
interface stb_in_if import stb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [ID_W-1:0]     timer_id;
	logic [PERIOD_W-1:0] period;
	logic                periodic;

	modport source(output valid, func, timer_id, period, periodic, input ready);
	modport sink(input valid, func, timer_id, period, periodic, output ready);
endinterface

interface stb_out_if import stb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               status;
	logic               expired;
	logic [ID_W-1:0]    result_timer;
	logic               is_active;
	logic [LEFT_W-1:0]  ticks_left;
	logic [COUNT_W-1:0] armed_count;
	logic               last;

	modport source(output valid, status, expired, result_timer, is_active, ticks_left,
		armed_count, last, input ready);
	modport sink(input valid, status, expired, result_timer, is_active, ticks_left,
		armed_count, last, output ready);
endinterface

// ===== design/software_timer_bank.sv =====
// Top level of the software timer bank: sequencer, timer memories and result register.
//
// A bank of NUM_TIMERS timers sharing a wrapping tick counter of TICK_WIDTH bits. Period
// and expiry of every timer live in two synchronous memories with a registered read;
// active flags and the live count sit in flip-flops. A command beat (configure, start,
// stop, restart, query) reads the addressed entry, then modifies it, writes it back and
// loads the result register once it is free. A tick beat gives 1 to 16 result beats: the
// sequencer sweeps the memories one entry per cycle, re-arming or retiring each expired
// timer, then issues the expiries in index order, one per cycle while the output is free.
// A new beat is accepted while the last result still waits in the output register.
// Out-of-range timer ids and unknown function codes return status 1.
module software_timer_bank import stb_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	stb_in_if.sink    cmd,
	stb_out_if.source res
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int LW = $clog2(NUM_TIMERS + 1);
	localparam int SW = (TICK_WIDTH > PERIOD_W) ? TICK_WIDTH : PERIOD_W;
	localparam int RW = $clog2(MAX_RESULTS);
	localparam int PW = PERIOD_W + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);
	localparam logic [RW-1:0] LAST_RES = RW'(MAX_RESULTS - 1);

	function automatic logic [TICK_WIDTH-1:0] tick_add(input logic [TICK_WIDTH-1:0] t,
		input logic [PERIOD_W-1:0] p);
		logic [SW-1:0] s;
		s = SW'(t) + SW'(p);
		return s[TICK_WIDTH-1:0];
	endfunction

	state_t st_q, st_d;

	// memories: {periodic, period} and expiry tick
	logic [PW-1:0]         per_mem [NUM_TIMERS];
	logic [TICK_WIDTH-1:0] exp_mem [NUM_TIMERS];
	logic [PW-1:0]         per_rd_s1;
	logic [TICK_WIDTH-1:0] exp_rd_s1;
	logic                  pv_rd_s1;
	logic [NUM_TIMERS-1:0] pv_q;

	logic [NUM_TIMERS-1:0] act_q;
	logic [NUM_TIMERS-1:0] hit_q;
	logic [LW-1:0]         live_q, live_d;
	logic [TICK_WIDTH-1:0] tick_q;
	logic [AW-1:0]         sc_q;
	logic [RW-1:0]         cnt_q;

	logic [FUNC_W-1:0]   func_q;
	logic [ID_W-1:0]     id_q;
	logic [AW-1:0]       idx_q;
	logic                id_ok_q;
	logic [PERIOD_W-1:0] per_in_q;
	logic                pf_in_q;

	res_t res_q, res_d;
	logic res_v_q;

	logic                  accept, ofree, emit;
	logic                  rd_en, exp_we, per_we, act_set, act_clr, hit_now, last_hit;
	logic [AW-1:0]         rd_addr, wa, low_idx;
	logic [TICK_WIDTH-1:0] exp_wd;
	logic [PW-1:0]         per_wd;
	logic [PERIOD_W-1:0]   stored_per, eff_per;
	logic                  stored_pf, cur_act, new_act;
	logic [TICK_WIDTH-1:0] diff;
	logic [SW-1:0]         diff_x;
	logic [LEFT_W-1:0]     left;
	logic [NUM_TIMERS-1:0] low_bit, hit_rest;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (st_q == ST_IDLE);
	assign ofree     = !res_v_q || res.ready;

	assign stored_per = pv_rd_s1 ? per_rd_s1[PERIOD_W-1:0] : '0;
	assign stored_pf  = pv_rd_s1 & per_rd_s1[PERIOD_W];

	// lowest pending expiry
	assign low_bit  = hit_q & (~hit_q + 1'b1);
	assign hit_rest = hit_q & ~low_bit;
	always_comb begin
		low_idx = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | AW'(i);
			end
		end
	end

	// ticks left for a query; past or far expiry reads as zero
	always_comb begin
		diff = exp_rd_s1 - tick_q;
		if (diff[TICK_WIDTH-1] && (diff[TICK_WIDTH-2:0] != '0)) begin
			diff = '0;
		end
		diff_x = SW'(diff);
		left   = ((diff_x >> LEFT_W) != '0) ? '1 : diff_x[LEFT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		exp_we   = 1'b0;
		per_we   = 1'b0;
		wa       = idx_q;
		exp_wd   = tick_add(tick_q, stored_per);
		per_wd   = {pf_in_q, per_in_q};
		act_set  = 1'b0;
		act_clr  = 1'b0;
		emit     = 1'b0;
		hit_now  = 1'b0;
		last_hit = (hit_rest == '0) || (cnt_q == LAST_RES);
		eff_per  = stored_per;
		cur_act  = act_q[idx_q];
		new_act  = 1'b0;
		live_d   = live_q;
		res_d    = '0;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = (cmd.func == FN_TICK) ? '0 : AW'(cmd.timer_id);
					st_d    = (cmd.func == FN_TICK) ? ST_SCAN : ST_CMD;
				end
			end
			ST_CMD: begin
				res_d.result_timer = id_q;
				res_d.last         = 1'b1;
				if ((func_q > FN_QUERY) || !id_ok_q) begin
					res_d.status = STATUS_INVAL;
				end else begin
					case (func_q)
						FN_CONFIG: begin
							if (per_in_q == '0) begin
								res_d.status = STATUS_INVAL;
							end else begin
								per_we  = 1'b1;
								act_clr = cur_act;
							end
						end
						FN_START: begin
							if (stored_per == '0) begin
								res_d.status = STATUS_INVAL;
							end else begin
								act_set = 1'b1;
								exp_we  = 1'b1;
							end
						end
						FN_STOP: begin
							act_clr = cur_act;
						end
						FN_RESTART: begin
							if ((per_in_q == '0) && (stored_per == '0)) begin
								res_d.status = STATUS_INVAL;
							end else begin
								if (per_in_q != '0) begin
									eff_per = per_in_q;
									per_we  = 1'b1;
									per_wd  = {stored_pf, per_in_q};
								end
								act_set = 1'b1;
								exp_we  = 1'b1;
								exp_wd  = tick_add(tick_q, eff_per);
							end
						end
						FN_QUERY: begin
							res_d.ticks_left = cur_act ? left : '0;
						end
						default: begin
							res_d.status = STATUS_INVAL;
						end
					endcase
					new_act         = (cur_act & ~act_clr) | act_set;
					res_d.is_active = new_act;
					if (act_set && !cur_act) begin
						live_d = live_q + 1'b1;
					end else if (act_clr) begin
						live_d = live_q - 1'b1;
					end
				end
				res_d.armed_count = COUNT_W'(live_d);
				// hold the whole update until the result register frees up
				if (ofree) begin
					emit = 1'b1;
					st_d = ST_IDLE;
				end else begin
					exp_we  = 1'b0;
					per_we  = 1'b0;
					act_set = 1'b0;
					act_clr = 1'b0;
					live_d  = live_q;
				end
			end
			ST_SCAN: begin
				wa      = sc_q;
				hit_now = act_q[sc_q] && (exp_rd_s1 == tick_q);
				if (hit_now) begin
					if (stored_pf) begin
						exp_we = 1'b1;
					end else begin
						act_clr = 1'b1;
						live_d  = live_q - 1'b1;
					end
				end
				if (sc_q == LAST_IDX) begin
					st_d = ST_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = sc_q + 1'b1;
				end
			end
			ST_EMIT: begin
				res_d.armed_count = COUNT_W'(live_q);
				if (hit_q == '0) begin
					res_d.last = 1'b1;
				end else begin
					res_d.expired      = 1'b1;
					res_d.result_timer = ID_W'(low_idx);
					res_d.is_active    = act_q[low_idx];
					res_d.last         = last_hit;
				end
				if (ofree) begin
					emit = 1'b1;
					if (res_d.last) begin
						st_d = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (per_we) begin
			per_mem[wa] <= per_wd;
		end
		if (exp_we) begin
			exp_mem[wa] <= exp_wd;
		end
		if (rd_en) begin
			per_rd_s1 <= per_mem[rd_addr];
			exp_rd_s1 <= exp_mem[rd_addr];
			pv_rd_s1  <= pv_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= cmd.func;
			id_q     <= cmd.timer_id;
			idx_q    <= AW'(cmd.timer_id);
			id_ok_q  <= (int'(cmd.timer_id) < NUM_TIMERS);
			per_in_q <= cmd.period;
			pf_in_q  <= cmd.periodic;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			act_q   <= '0;
			hit_q   <= '0;
			live_q  <= '0;
			tick_q  <= '0;
			sc_q    <= '0;
			cnt_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (per_we) begin
				pv_q[wa] <= 1'b1;
			end
			if (act_set) begin
				act_q[wa] <= 1'b1;
			end else if (act_clr) begin
				act_q[wa] <= 1'b0;
			end
			live_q <= live_d;
			if (accept && (cmd.func == FN_TICK)) begin
				tick_q <= tick_q + 1'b1;
				sc_q   <= '0;
				hit_q  <= '0;
				cnt_q  <= '0;
			end
			if (st_q == ST_SCAN) begin
				hit_q[sc_q] <= hit_now;
				sc_q        <= sc_q + 1'b1;
			end
			if ((st_q == ST_EMIT) && emit) begin
				hit_q <= hit_rest;
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign res.valid        = res_v_q;
	assign res.status       = res_q.status;
	assign res.expired      = res_q.expired;
	assign res.result_timer = res_q.result_timer;
	assign res.is_active    = res_q.is_active;
	assign res.ticks_left   = res_q.ticks_left;
	assign res.armed_count  = res_q.armed_count;
	assign res.last         = res_q.last;

	a_live_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		int'(live_q) == $countones(act_q))
		else $error("live count out of step with active flags");

	a_tick_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.func == FN_TICK)) |=> (tick_q == $past(tick_q) + 1'b1))
		else $error("tick counter did not advance on a tick beat");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_we && rd_en) |-> (wa != rd_addr))
		else $error("expiry write collides with read of the same entry");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ofree)
		else $error("result loaded over a beat not yet taken");

endmodule

// ===== test/software_timer_bank_tb.sv =====
// Self-checking testbench of the software timer bank: random command and tick beats, predicted results.
`timescale 1ns / 1ps

module software_timer_bank_tb;
	import stb_pkg::*;

	localparam int N_TMR = NUM_TIMERS_DEF;
	localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;
	localparam logic [TICK_WIDTH_DEF-1:0] HALF_RANGE = 32'h8000_0000;
	localparam int BEAT_TARGET = 420;
	localparam int DRAIN_EVERY = 70;

	typedef struct {
		logic [FUNC_W-1:0]   func;
		logic [ID_W-1:0]     timer_id;
		logic [PERIOD_W-1:0] period;
		logic                periodic;
		bit                  drain;
	} cmd_beat_t;

	logic clk;
	logic arst_n;

	stb_in_if  cmd_ch();
	stb_out_if res_ch();

	software_timer_bank dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// predicted bank state
	logic [TICK_WIDTH_DEF-1:0] expiry_at [N_TMR];
	logic [PERIOD_W-1:0]       period_of [N_TMR];
	logic                      repeats [N_TMR];
	logic                      armed [N_TMR];
	logic [TICK_WIDTH_DEF-1:0] tick_count;
	logic [COUNT_W-1:0]        armed_total;

	cmd_beat_t cmd_backlog[$];
	res_t      due_results[$];
	cmd_beat_t cur_beat;
	bit        drain_next;
	int        beat_total;
	int        beats_taken;
	int        results_owed;
	int        results_seen;
	int        fails;
	logic      calm;

	// both sides drop their random gaps over a stretch in the middle
	assign calm = beats_taken >= 180 && beats_taken < 300;

	task automatic arm_timer(input int id);
		if (!armed[id]) begin
			armed[id] = 1'b1;
			armed_total = armed_total + 1'b1;
		end
		expiry_at[id] = tick_count + period_of[id];
	endtask

	task automatic run_timer_bank(input cmd_beat_t b, output int n);
		res_t r;
		int hit_ids[$];
		int id;
		logic [TICK_WIDTH_DEF-1:0] d;
		r = '0;
		r.last = 1'b1;
		id = b.timer_id;
		n = 1;
		if (b.func == FN_TICK) begin
			tick_count = tick_count + 1'b1;
			for (int t = 0; t < N_TMR; t++) begin
				if (armed[t] && expiry_at[t] == tick_count) begin
					if (repeats[t]) begin
						expiry_at[t] = tick_count + period_of[t];
					end else begin
						armed[t] = 1'b0;
						armed_total = armed_total - 1'b1;
					end
					if (hit_ids.size() < MAX_RESULTS)
						hit_ids.push_back(t);
				end
			end
			r.armed_count = armed_total;
			if (hit_ids.size() == 0) begin
				due_results.push_back(r);
			end else begin
				n = hit_ids.size();
				foreach (hit_ids[k]) begin
					r.expired = 1'b1;
					r.result_timer = ID_W'(hit_ids[k]);
					r.is_active = armed[hit_ids[k]];
					r.last = (k == hit_ids.size() - 1);
					due_results.push_back(r);
				end
			end
		end else begin
			r.result_timer = b.timer_id;
			case (b.func)
				FN_CONFIG: begin
					if (b.period == 0) begin
						r.status = STATUS_INVAL;
					end else begin
						if (armed[id]) begin
							armed[id] = 1'b0;
							armed_total = armed_total - 1'b1;
						end
						period_of[id] = b.period;
						repeats[id] = b.periodic;
						expiry_at[id] = '0;
					end
				end
				FN_START: begin
					if (period_of[id] == 0)
						r.status = STATUS_INVAL;
					else
						arm_timer(id);
				end
				FN_STOP: begin
					if (armed[id]) begin
						armed[id] = 1'b0;
						armed_total = armed_total - 1'b1;
					end
				end
				FN_RESTART: begin
					if (b.period == 0 && period_of[id] == 0) begin
						r.status = STATUS_INVAL;
					end else begin
						if (b.period != 0)
							period_of[id] = b.period;
						arm_timer(id);
					end
				end
				FN_QUERY: begin
					if (armed[id]) begin
						d = expiry_at[id] - tick_count;
						// far or already passed: report nothing left
						r.ticks_left = (d > HALF_RANGE) ? '0 : d;
					end
				end
				default: r.status = STATUS_INVAL;
			endcase
			r.is_active = (b.func <= FN_QUERY) ? armed[id] : 1'b0;
			r.armed_count = armed_total;
			due_results.push_back(r);
		end
	endtask

	task automatic add_beat(input logic [FUNC_W-1:0] f, input int id,
		input logic [PERIOD_W-1:0] p, input int rep);
		cmd_beat_t b;
		b.func = f;
		b.timer_id = ID_W'(id);
		b.period = p;
		b.periodic = rep[0];
		b.drain = drain_next;
		drain_next = 1'b0;
		cmd_backlog.push_back(b);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < 70)
			return $urandom_range(1, 6);
		else if (r < 82)
			return $urandom;
		else if (r < 90)
			return 32'h7FFF_FFFE + $urandom_range(0, 4);
		else
			return 32'hFFFF_FFFF - $urandom_range(0, 2);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("software_timer_bank_tb: FAIL");
		$finish;
	end

	// driver: present backlog beats, predict on every accepted beat
	always @(posedge clk) begin
		int n;
		bit took;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			took = cmd_ch.valid && cmd_ch.ready;
			if (took) begin
				run_timer_bank(cur_beat, n);
				results_owed <= results_owed + n;
				beats_taken <= beats_taken + 1;
			end
			if (took || !cmd_ch.valid) begin
				if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].drain && (took || results_owed != results_seen)) &&
					(calm || $urandom_range(99) >= 12)) begin
					cur_beat = cmd_backlog.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.func <= cur_beat.func;
					cmd_ch.timer_id <= cur_beat.timer_id;
					cmd_ch.period <= cur_beat.period;
					cmd_ch.periodic <= cur_beat.periodic;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen <= results_seen + 1;
				if (due_results.size() == 0) begin
					$error("result beat with nothing expected: timer %0d", res_ch.result_timer);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, res_ch.status);
					check_field("expired", want.expired, res_ch.expired);
					check_field("result_timer", want.result_timer, res_ch.result_timer);
					check_field("is_active", want.is_active, res_ch.is_active);
					check_field("ticks_left", want.ticks_left, res_ch.ticks_left);
					check_field("armed_count", want.armed_count, res_ch.armed_count);
					check_field("last", want.last, res_ch.last);
				end
			end
			res_ch.ready <= calm || $urandom_range(99) >= 12;
		end
	end

	initial begin
		int roll;
		int k;
		int next_drain;
		int burst_ids[N_TMR];
		logic [PERIOD_W-1:0] p;
		logic [FUNC_W-1:0] f;

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FN_TICK;
		cmd_ch.timer_id = '0;
		cmd_ch.period = '0;
		cmd_ch.periodic = 1'b0;
		res_ch.ready = 1'b0;
		fails = 0;
		beats_taken = 0;
		results_owed = 0;
		results_seen = 0;
		drain_next = 1'b0;
		tick_count = '0;
		armed_total = '0;
		for (int t = 0; t < N_TMR; t++) begin
			expiry_at[t] = '0;
			period_of[t] = '0;
			repeats[t] = 1'b0;
			armed[t] = 1'b0;
		end

		// zero stored period rejects start and restart
		add_beat(FN_START, 15, 32'd0, 0);
		add_beat(FN_RESTART, 15, 32'd0, 0);
		// write every entry before any tick scans it
		for (int t = 0; t < N_TMR; t++) begin
			p = (t == 2) ? 32'hFFFF_FFFF : (t == 3) ? 32'h8000_0000 : (t < 2) ? 32'd1 : t;
			add_beat(FN_CONFIG, t, p, t % 2);
		end
		add_beat(FN_CONFIG, 0, 32'd0, 1);
		add_beat(FN_START, 0, 32'd0, 0);
		add_beat(FN_START, 1, 32'hFFFF_FFFF, 0);
		add_beat(FN_RESTART, 2, 32'd0, 0);
		add_beat(FN_RESTART, 3, 32'd0, 0);
		add_beat(FN_TICK, 0, 32'd0, 0);
		add_beat(FN_QUERY, 2, 32'd0, 0);
		add_beat(FN_QUERY, 3, 32'd0, 0);
		add_beat(FN_STOP, 9, 32'd0, 0);
		add_beat(FN_CONFIG, 1, 32'd5, 1);
		add_beat(FN_START, 2, 32'd7, 1);
		add_beat(FN_BAD_LO, 4, 32'd5, 1);
		add_beat(FN_BAD_HI, 11, 32'h1234_5678, 0);
		add_beat(FN_TICK, 7, 32'd9, 1);

		next_drain = cmd_backlog.size() + DRAIN_EVERY;
		drain_next = 1'b1;
		while (cmd_backlog.size() < BEAT_TARGET) begin
			if (cmd_backlog.size() >= next_drain) begin
				drain_next = 1'b1;
				next_drain += DRAIN_EVERY;
			end
			roll = $urandom_range(99);
			if (roll < 8) begin
				// arm a group on one period so they expire together
				k = (roll < 3) ? N_TMR : $urandom_range(2, 6);
				p = $urandom_range(1, 3);
				for (int j = 0; j < k; j++) begin
					burst_ids[j] = (k == N_TMR) ? j : $urandom_range(0, N_TMR - 1);
					add_beat(FN_CONFIG, burst_ids[j], p, $urandom_range(0, 1));
				end
				for (int j = 0; j < k; j++)
					add_beat(FN_START, burst_ids[j], $urandom, $urandom_range(0, 1));
				repeat ($urandom_range(p, p + 2))
					add_beat(FN_TICK, $urandom_range(0, N_TMR - 1), $urandom, $urandom_range(0, 1));
			end else begin
				roll = $urandom_range(99);
				if (roll < 14)
					f = FN_CONFIG;
				else if (roll < 28)
					f = FN_START;
				else if (roll < 36)
					f = FN_STOP;
				else if (roll < 48)
					f = FN_RESTART;
				else if (roll < 84)
					f = FN_TICK;
				else if (roll < 96)
					f = FN_QUERY;
				else
					f = $urandom_range(0, 1) ? FN_BAD_HI : FN_BAD_LO;
				add_beat(f, $urandom_range(0, N_TMR - 1), pick_period(), $urandom_range(0, 1));
			end
		end
		beat_total = cmd_backlog.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (beats_taken == beat_total && results_owed == results_seen);
		repeat (40) @(posedge clk);
		if (fails == 0 && due_results.size() == 0)
			$display("software_timer_bank_tb: PASS");
		else
			$display("software_timer_bank_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/stb_pkg.sv
design/stb_ifs.sv
design/software_timer_bank.sv
test/software_timer_bank_tb.sv
